// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  // Operation codes carried on the op field.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/spq_cell.sv =====
// One storage cell of the sorted chain: holds one value and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire spq_cell_ctrl_t        ctrl_i,
  input  wire logic                  occupied_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic [VALUE_BITS-1:0] left_entry_i,
  input  wire logic                  left_ge_i,
  input  wire logic [VALUE_BITS-1:0] right_entry_i,
  output logic      [VALUE_BITS-1:0] entry_o,
  output logic                       ge_o
);

  logic [VALUE_BITS-1:0] entry_q;
  logic [VALUE_BITS-1:0] entry_d;

  // A held value stays put when it is at least the new one; equal values keep their place.
  assign ge_o = occupied_i && ($signed(entry_q) >= $signed(value_i));

  // Insert: keep, take the new value at the boundary, or take the left neighbor.
  // Remove: take the right neighbor so everything moves one place up.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (ge_o) begin
        entry_d = entry_q;
      end else if (left_ge_i) begin
        entry_d = value_i;
      end else begin
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  // Value storage needs no reset; only entries below the fill count are ever observed.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ===== hdl/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: a chain of compare-and-shift cells.
// The result of an accepted item is presented in the cycle after its transfer.
// Throughput: one item per cycle while the output does not stall; every cell compares and shifts in parallel.
// The input stalls only while a finished result is held by a stall on the output.
// Reset clears the fill count and the output valid; the stored values are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  op_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [VALUE_BITS-1:0] largest_o,
  output logic      [VALUE_BITS-1:0] smallest_o,
  output logic      [CNT_W-1:0]      count_o,
  output logic                       full_res_o,
  output logic                       empty_res_o,
  output logic                       rejected_o
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                  out_valid_q;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [VALUE_BITS-1:0] smallest_q, smallest_d;
  logic                  rejected_q;
  logic                  in_xfer;
  logic                  is_full, is_empty;
  spq_cell_ctrl_t        ctrl;

  logic [VALUE_BITS-1:0] entry    [CAPACITY];
  logic                  ge       [CAPACITY];

  // A new item may enter whenever the output register is free or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign is_full  = (fill_q == CAP_CNT);
  assign is_empty = (fill_q == '0);

  // Command for the chain; rejected operations leave every cell untouched.
  always_comb begin
    ctrl.ins = in_xfer && (op_i == OP_INSERT) && !is_full;
    ctrl.rem = in_xfer && (op_i == OP_REMOVE) && !is_empty;
  end

  // The chain of cells, entry 0 holding the largest value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_entry;
    logic                  left_ge;
    logic [VALUE_BITS-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_entry = value_i;
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_entry = entry[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    spq_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (fill_q > CNT_W'(i)),
      .value_i      (value_i),
      .left_entry_i (left_entry),
      .left_ge_i    (left_ge),
      .right_entry_i(right_entry),
      .entry_o      (entry[i]),
      .ge_o         (ge[i])
    );
  end

  // Fill count and smallest value. Removing the largest never changes the smallest;
  // an insert lands at the tail when it does not exceed the current smallest.
  always_comb begin
    fill_d     = fill_q;
    smallest_d = smallest_q;
    if (ctrl.ins) begin
      fill_d = fill_q + CNT_W'(1);
      if (is_empty || ($signed(value_i) <= $signed(smallest_q))) begin
        smallest_d = value_i;
      end
    end else if (ctrl.rem) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; the fill count only moves on a transfer, so it matches the held result.
  always_ff @(posedge clk_i) begin
    smallest_q <= smallest_d;
    if (in_xfer) begin
      rejected_q <= !(ctrl.ins || ctrl.rem);
    end
  end

  assign out_valid_o = out_valid_q;
  assign largest_o   = is_empty ? '0 : entry[0];
  assign smallest_o  = is_empty ? '0 : smallest_q;
  assign count_o     = fill_q;
  assign full_res_o  = is_full;
  assign empty_res_o = is_empty;
  assign rejected_o  = rejected_q;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sorted priority queue core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import spq_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1);
  localparam int          RANDOM_ITEMS = 1430;
  localparam int          LONG_HOLD    = 300;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          SHOW_LIMIT   = 10;

  // One result transfer: the queue summary after one operation.
  typedef struct packed {
    logic [VALUE_BITS-1:0] largest;
    logic [VALUE_BITS-1:0] smallest;
    logic [CNT_W-1:0]      count;
    logic                  full_res;
    logic                  empty_res;
    logic                  rejected;
  } queue_summary_t;

  // Tracks the sorted contents and checks every summary against them.
  class queue_scoreboard;
    logic signed [VALUE_BITS-1:0] sorted_vals[$];
    queue_summary_t               summaries_due[$];
    int mismatches, checked, inserts, removes, rejects, full_hits, empty_hits;

    function new();
      mismatches = 0;
      checked    = 0;
      inserts    = 0;
      removes    = 0;
      rejects    = 0;
      full_hits  = 0;
      empty_hits = 0;
    endfunction

    function int pending();
      return summaries_due.size();
    endfunction

    function int fill();
      return sorted_vals.size();
    endfunction

    // Apply one accepted operation and queue the summary it must produce.
    function void note_item(logic op, logic [VALUE_BITS-1:0] value);
      logic signed [VALUE_BITS-1:0] v;
      queue_summary_t               s;
      int                           pos;
      v = $signed(value);
      s = '0;
      if (op == OP_INSERT) begin
        inserts++;
        if (sorted_vals.size() >= CAPACITY) begin
          s.rejected = 1'b1;
        end else begin
          // Equal values stay ahead of the new one.
          pos = 0;
          while (pos < sorted_vals.size() && sorted_vals[pos] >= v) pos++;
          sorted_vals.insert(pos, v);
        end
      end else begin
        removes++;
        if (sorted_vals.size() == 0) s.rejected = 1'b1;
        else void'(sorted_vals.pop_front());
      end
      if (sorted_vals.size() != 0) begin
        s.largest  = sorted_vals[0];
        s.smallest = sorted_vals[sorted_vals.size() - 1];
      end
      s.count     = CNT_W'(sorted_vals.size());
      s.full_res  = (sorted_vals.size() == CAPACITY);
      s.empty_res = (sorted_vals.size() == 0);
      if (s.rejected) rejects++;
      if (s.full_res) full_hits++;
      if (s.empty_res) empty_hits++;
      summaries_due.push_back(s);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= SHOW_LIMIT) $display("Mismatch: %s", msg);
    endfunction

    // Compare one result transfer with the oldest expected summary.
    function void check_result(queue_summary_t got);
      queue_summary_t want;
      if (summaries_due.size() == 0) begin
        report($sformatf("result with nothing expected: largest %0d count %0d",
                         $signed(got.largest), got.count));
        return;
      end
      want = summaries_due.pop_front();
      checked++;
      if (got.largest !== want.largest)
        report($sformatf("largest exp %0d got %0d", $signed(want.largest),
                         $signed(got.largest)));
      if (got.smallest !== want.smallest)
        report($sformatf("smallest exp %0d got %0d", $signed(want.smallest),
                         $signed(got.smallest)));
      if (got.count !== want.count)
        report($sformatf("count exp %0d got %0d", want.count, got.count));
      if (got.full_res !== want.full_res)
        report($sformatf("full exp %0b got %0b", want.full_res, got.full_res));
      if (got.empty_res !== want.empty_res)
        report($sformatf("empty exp %0b got %0b", want.empty_res, got.empty_res));
      if (got.rejected !== want.rejected)
        report($sformatf("rejected exp %0b got %0b", want.rejected, got.rejected));
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  op_i        = OP_INSERT;
  logic [VALUE_BITS-1:0] value_i     = '0;
  logic                  out_stall_i = 1'b0;
  logic                  hold_req    = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [VALUE_BITS-1:0] largest_o;
  logic [VALUE_BITS-1:0] smallest_o;
  logic [CNT_W-1:0]      count_o;
  logic                  full_res_o;
  logic                  empty_res_o;
  logic                  rejected_o;

  queue_scoreboard sb;

  sorted_priority_queue_core #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .largest_o  (largest_o),
    .smallest_o (smallest_o),
    .count_o    (count_o),
    .full_res_o (full_res_o),
    .empty_res_o(empty_res_o),
    .rejected_o (rejected_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{largest_o, smallest_o, count_o, full_res_o, empty_res_o,
                        rejected_o});
  end

  // Output stall pattern; a requested long hold-off takes precedence.
  initial begin : rx_stall
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_left = LONG_HOLD - 1;
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // End the run if no transfer happens for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Offer one operation and hold it until the transfer.
  task automatic send_item(input logic op, input logic [VALUE_BITS-1:0] value);
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, value);
  endtask

  task automatic idle_input(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop offering until every expected result has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mix of extremes, small values that collide, and full-range random values.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    logic [VALUE_BITS-1:0] edge_vals[8];
    logic                  op;
    int                    steer;
    int                    steer_left;
    int                    burst_left;
    int                    no_gap_left;
    sb = new();
    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0001};
    steer       = 0;
    steer_left  = 0;
    burst_left  = 0;
    no_gap_left = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: remove on empty, extremes and duplicates, then drain past empty.
    send_item(OP_REMOVE, 32'hFFFF_FFFF);
    foreach (edge_vals[k]) send_item(OP_INSERT, edge_vals[k]);
    repeat (9) send_item(OP_REMOVE, $urandom());
    wait_drained();

    // Random: phases biased toward filling, draining, or balanced traffic.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (steer_left == 0) begin
        steer      = $urandom_range(0, 2);
        steer_left = $urandom_range(10, 60);
      end
      steer_left--;
      case (steer)
        0: op = ($urandom_range(0, 9) < 8) ? OP_INSERT : OP_REMOVE;
        1: op = ($urandom_range(0, 9) < 8) ? OP_REMOVE : OP_INSERT;
        default: op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_REMOVE;
      endcase
      send_item(op, (op == OP_INSERT) ? pick_value() : $urandom());

      // Long output hold-off while the input keeps offering.
      if (n == 400 || n == 1100) begin
        hold_req    <= 1'b1;
        no_gap_left = 40;
      end
      if (n % 350 == 349) wait_drained();

      if (no_gap_left > 0) begin
        no_gap_left--;
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        idle_input($urandom_range(1, 8));
        burst_left = $urandom_range(1, 40);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d inserts and %0d removes, %0d rejected; full seen %0d times, empty %0d.",
             sb.inserts, sb.removes, sb.rejects, sb.full_hits, sb.empty_hits);
    $display("Checked %0d results with %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sorted_priority_queue_core.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
tb/tb_top.sv
